FILE: design/cdt_pkg.sv
// Shared types and codes for the mm:ss countdown timer.
// Holds the request and result payload structs, the input, mode and cue codes and the register map.
// No dependencies.
package cdt_pkg;

  // Input function codes
  localparam logic [1:0] FUNC_TICK   = 2'd0;
  localparam logic [1:0] FUNC_TOUCH  = 2'd1;
  localparam logic [1:0] FUNC_REPEAT = 2'd2;

  // Button codes
  localparam logic [3:0] BTN_START = 4'd0;
  localparam logic [3:0] BTN_STOP  = 4'd1;
  localparam logic [3:0] BTN_RESET = 4'd2;
  localparam logic [3:0] BTN_MT_UP = 4'd3;
  localparam logic [3:0] BTN_MO_UP = 4'd4;
  localparam logic [3:0] BTN_MT_DN = 4'd5;
  localparam logic [3:0] BTN_MO_DN = 4'd6;
  localparam logic [3:0] BTN_ST_UP = 4'd7;
  localparam logic [3:0] BTN_SO_UP = 4'd8;
  localparam logic [3:0] BTN_ST_DN = 4'd9;
  localparam logic [3:0] BTN_SO_DN = 4'd10;

  // Mode codes as shown on the result channel
  localparam logic [2:0] MODE_EDIT   = 3'd0;
  localparam logic [2:0] MODE_RUN    = 3'd1;
  localparam logic [2:0] MODE_PAUSE  = 3'd2;
  localparam logic [2:0] MODE_SOUND  = 3'd3;
  localparam logic [2:0] MODE_SILENT = 3'd4;

  // Sound cue codes
  localparam logic [1:0] CUE_NONE  = 2'd0;
  localparam logic [1:0] CUE_CLICK = 2'd1;
  localparam logic [1:0] CUE_BEEP  = 2'd2;

  // Register map
  localparam int unsigned CFG_ADDR_W = 3;
  localparam logic        REG_TPS    = 1'b0;
  localparam logic [15:0] TPS_RESET  = 16'd60;

  typedef struct packed {
    logic [1:0] func;
    logic [3:0] button;
  } in_t;

  typedef struct packed {
    logic [3:0] minutes_tens;
    logic [3:0] minutes_ones;
    logic [2:0] seconds_tens;
    logic [3:0] seconds_ones;
    logic [2:0] mode;
    logic [1:0] sound_cue;
    logic       digits_changed;
    logic       alarm_started;
  } out_t;

endpackage

FILE: design/countdown_timer_mmss.sv
// Top level of the mm:ss countdown timer: input register, timer core, result register.
// Depends on cdt_pkg, cdt_regs and cdt_core.
//
// Usage:
//   Each request on the in_ channel is one tick (func 0) or a button touch or
//   auto-repeat (func 1 or 2) with a button code. Every request yields exactly
//   one result on the out_ channel: the four shown digits, the mode, a sound
//   cue and the digits_changed and alarm_started flags.
//   A request is taken at a clock edge with in_valid high and in_stall low;
//   a result is delivered at an edge with out_valid high and out_stall low.
//   A taken request waits in the input register until the result register
//   can load its result. Throughput: one request per cycle while out_stall
//   is low. The core updates all timer state between the two registers.
//   Stalls: while out_stall holds a result, the input register still takes
//   one more request; in_stall rises only when both registers are full.
//   Configuration: ticks_per_second sits at byte address 0 of the APB-style
//   port; write it only while the timer is idle.
//   Reset (rst_n low, synchronous): edit mode, digits 00:00, counters cleared,
//   ticks_per_second back to 60, both registers empty.
module countdown_timer_mmss (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  cdt_pkg::in_t                   in_data,
  output logic                           out_valid,
  input  logic                           out_stall,
  output cdt_pkg::out_t                  out_data,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [cdt_pkg::CFG_ADDR_W-1:0] paddr,
  input  logic [31:0]                    pwdata,
  output logic [31:0]                    prdata,
  output logic                           pready
);

  logic          s1_valid_r, s1_valid_nxt;
  cdt_pkg::in_t  s1_item_r;
  logic          out_valid_r, out_valid_nxt;
  cdt_pkg::out_t out_data_r;
  cdt_pkg::out_t core_result;
  logic [15:0]   tps;
  logic          out_load;
  logic          s1_fire;
  logic          in_accept;

  cdt_regs u_regs (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .tps     (tps)
  );

  cdt_core u_core (
    .clk    (clk),
    .rst_n  (rst_n),
    .fire   (s1_fire),
    .item   (s1_item_r),
    .tps    (tps),
    .result (core_result)
  );

  // Result register loads when empty or when its result leaves this cycle
  assign out_load  = !out_valid_r || !out_stall;
  // Advance the held request into the core and the result register
  assign s1_fire   = s1_valid_r && out_load;
  assign in_stall  = s1_valid_r && !out_load;
  assign in_accept = in_valid && !in_stall;

  assign s1_valid_nxt  = in_accept ? 1'b1 : (s1_fire ? 1'b0 : s1_valid_r);
  assign out_valid_nxt = s1_fire ? 1'b1 : (out_valid_r && out_stall);

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers: hold unless a new request or result moves in
  always_ff @(posedge clk) begin
    if (in_accept) begin
      s1_item_r <= in_data;
    end
    if (s1_fire) begin
      out_data_r <= core_result;
    end
  end

endmodule

FILE: design/cdt_regs.sv
// Configuration register file of the countdown timer (APB-style slave).
// Holds ticks_per_second; depends on cdt_pkg.
module cdt_regs (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [cdt_pkg::CFG_ADDR_W-1:0] paddr,
  input  logic [31:0]                    pwdata,
  output logic [31:0]                    prdata,
  output logic                           pready,
  output logic [15:0]                    tps
);

  logic [15:0] tps_r;
  logic [15:0] tps_nxt;
  logic        wr_en;
  logic        sel_tps;

  assign pready  = 1'b1;
  assign sel_tps = (paddr[2] == cdt_pkg::REG_TPS);
  assign wr_en   = psel && penable && pwrite && sel_tps;
  assign tps_nxt = wr_en ? pwdata[15:0] : tps_r;
  assign prdata  = sel_tps ? {16'd0, tps_r} : 32'd0;
  assign tps     = tps_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tps_r <= cdt_pkg::TPS_RESET;
    end else begin
      tps_r <= tps_nxt;
    end
  end

endmodule

FILE: design/cdt_core.sv
// Timer state and next-state logic: mode, shown digits, set and elapsed seconds.
// Updates state on each request taken from the input register; depends on cdt_pkg.
module cdt_core (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          fire,
  input  cdt_pkg::in_t  item,
  input  logic [15:0]   tps,
  output cdt_pkg::out_t result
);

  typedef enum logic [2:0] {
    ST_EDIT   = cdt_pkg::MODE_EDIT,
    ST_RUN    = cdt_pkg::MODE_RUN,
    ST_PAUSE  = cdt_pkg::MODE_PAUSE,
    ST_SOUND  = cdt_pkg::MODE_SOUND,
    ST_SILENT = cdt_pkg::MODE_SILENT
  } mode_t;

  mode_t       mode_r, mode_nxt;
  logic [3:0]  d0_r, d0_nxt;
  logic [3:0]  d1_r, d1_nxt;
  logic [2:0]  d2_r, d2_nxt;
  logic [3:0]  d3_r, d3_nxt;
  logic [12:0] set_r, set_nxt;
  logic [12:0] elap_r, elap_nxt;
  logic [15:0] sub_r, sub_nxt;
  logic        cnt_r, cnt_nxt;

  logic [1:0]  cue;
  logic        alarm;
  logic        touch;
  logic [15:0] limit;
  logic [15:0] sub_inc;
  logic        sec_adv;
  logic [12:0] elap_inc;
  logic [6:0]  mins;
  logic [5:0]  secs;
  logic [12:0] start_set;

  // Step a digit up or down, wrapping at lim
  function automatic logic [3:0] digit_step(input logic [3:0] d, input logic [3:0] lim,
                                             input logic up);
    if (up) begin
      digit_step = (d >= lim) ? 4'd0 : d + 4'd1;
    end else begin
      digit_step = (d == 4'd0 || d > lim) ? lim : d - 4'd1;
    end
  endfunction

  assign touch     = (item.func == cdt_pkg::FUNC_TOUCH);
  assign limit     = (tps == 16'd0) ? 16'd1 : tps;
  assign sub_inc   = sub_r + 16'd1;
  assign sec_adv   = (sub_inc >= limit);
  assign elap_inc  = elap_r + 13'(sec_adv);
  assign mins      = 7'(d0_r) * 7'd10 + 7'(d1_r);
  assign secs      = 6'(d2_r) * 6'd10 + 6'(d3_r);
  assign start_set = 13'(mins) * 13'd60 + 13'(secs);

  always_comb begin
    mode_nxt = mode_r;
    d0_nxt   = d0_r;
    d1_nxt   = d1_r;
    d2_nxt   = d2_r;
    d3_nxt   = d3_r;
    set_nxt  = set_r;
    elap_nxt = elap_r;
    sub_nxt  = sub_r;
    cnt_nxt  = cnt_r;
    cue      = cdt_pkg::CUE_NONE;
    alarm    = 1'b0;

    case (item.func)
      cdt_pkg::FUNC_TICK: begin
        if (mode_r == ST_RUN) begin
          sub_nxt  = sec_adv ? 16'd0 : sub_inc;
          elap_nxt = elap_inc;
          if (cnt_r) begin
            if (elap_inc >= set_r) begin
              cnt_nxt  = 1'b0;
              d0_nxt   = 4'd0;
              d1_nxt   = 4'd0;
              d2_nxt   = 3'd0;
              d3_nxt   = 4'd0;
              alarm    = 1'b1;
              mode_nxt = ST_SOUND;
            end else if (sec_adv) begin
              // Shown digits track set minus elapsed: count down by one second
              if (d3_r != 4'd0) begin
                d3_nxt = d3_r - 4'd1;
              end else begin
                d3_nxt = 4'd9;
                if (d2_r != 3'd0) begin
                  d2_nxt = d2_r - 3'd1;
                end else begin
                  d2_nxt = 3'd5;
                  if (d1_r != 4'd0) begin
                    d1_nxt = d1_r - 4'd1;
                  end else begin
                    d1_nxt = 4'd9;
                    d0_nxt = d0_r - 4'd1;
                  end
                end
              end
            end
          end
        end
      end
      cdt_pkg::FUNC_TOUCH, cdt_pkg::FUNC_REPEAT: begin
        case (mode_r)
          ST_EDIT: begin
            if (touch && item.button == cdt_pkg::BTN_START) begin
              // Digits already equal the loaded time, so they stay as they are
              cue      = cdt_pkg::CUE_CLICK;
              cnt_nxt  = 1'b1;
              elap_nxt = 13'd0;
              sub_nxt  = 16'd0;
              set_nxt  = start_set;
              if (start_set != 13'd0) begin
                mode_nxt = ST_RUN;
              end
            end else if (touch && item.button == cdt_pkg::BTN_STOP) begin
              cue = cdt_pkg::CUE_BEEP;
            end else if (touch && item.button == cdt_pkg::BTN_RESET) begin
              cue     = cdt_pkg::CUE_CLICK;
              cnt_nxt = 1'b0;
              d0_nxt  = 4'd0;
              d1_nxt  = 4'd0;
              d2_nxt  = 3'd0;
              d3_nxt  = 4'd0;
            end else begin
              case (item.button)
                cdt_pkg::BTN_MT_UP: d0_nxt = digit_step(d0_r, 4'd9, 1'b1);
                cdt_pkg::BTN_MO_UP: d1_nxt = digit_step(d1_r, 4'd9, 1'b1);
                cdt_pkg::BTN_MT_DN: d0_nxt = digit_step(d0_r, 4'd9, 1'b0);
                cdt_pkg::BTN_MO_DN: d1_nxt = digit_step(d1_r, 4'd9, 1'b0);
                cdt_pkg::BTN_ST_UP: d2_nxt = 3'(digit_step({1'b0, d2_r}, 4'd5, 1'b1));
                cdt_pkg::BTN_SO_UP: d3_nxt = digit_step(d3_r, 4'd9, 1'b1);
                cdt_pkg::BTN_ST_DN: d2_nxt = 3'(digit_step({1'b0, d2_r}, 4'd5, 1'b0));
                cdt_pkg::BTN_SO_DN: d3_nxt = digit_step(d3_r, 4'd9, 1'b0);
                default: ;
              endcase
            end
          end
          ST_RUN: begin
            if (touch) begin
              if (item.button == cdt_pkg::BTN_START) begin
                cue = cdt_pkg::CUE_BEEP;
              end else if (item.button == cdt_pkg::BTN_STOP) begin
                cue      = cdt_pkg::CUE_CLICK;
                cnt_nxt  = 1'b0;
                mode_nxt = ST_PAUSE;
              end else if (item.button == cdt_pkg::BTN_RESET) begin
                cue      = cdt_pkg::CUE_CLICK;
                cnt_nxt  = 1'b0;
                d0_nxt   = 4'd0;
                d1_nxt   = 4'd0;
                d2_nxt   = 3'd0;
                d3_nxt   = 4'd0;
                mode_nxt = ST_EDIT;
              end
            end
          end
          ST_PAUSE: begin
            if (touch) begin
              if (item.button == cdt_pkg::BTN_START) begin
                cue      = cdt_pkg::CUE_CLICK;
                cnt_nxt  = 1'b1;
                mode_nxt = ST_RUN;
              end else if (item.button == cdt_pkg::BTN_STOP) begin
                cue = cdt_pkg::CUE_BEEP;
              end else if (item.button == cdt_pkg::BTN_RESET) begin
                cue      = cdt_pkg::CUE_CLICK;
                cnt_nxt  = 1'b0;
                d0_nxt   = 4'd0;
                d1_nxt   = 4'd0;
                d2_nxt   = 3'd0;
                d3_nxt   = 4'd0;
                mode_nxt = ST_EDIT;
              end
            end
          end
          ST_SOUND: begin
            if (touch) begin
              if (item.button == cdt_pkg::BTN_START) begin
                cue = cdt_pkg::CUE_BEEP;
              end else if (item.button == cdt_pkg::BTN_STOP) begin
                cue      = cdt_pkg::CUE_CLICK;
                mode_nxt = ST_SILENT;
              end else if (item.button == cdt_pkg::BTN_RESET) begin
                cue      = cdt_pkg::CUE_CLICK;
                mode_nxt = ST_EDIT;
              end
            end
          end
          default: begin
            if (touch) begin
              if (item.button == cdt_pkg::BTN_START) begin
                cue      = cdt_pkg::CUE_CLICK;
                mode_nxt = ST_SOUND;
              end else if (item.button == cdt_pkg::BTN_STOP) begin
                cue = cdt_pkg::CUE_BEEP;
              end else if (item.button == cdt_pkg::BTN_RESET) begin
                cue      = cdt_pkg::CUE_CLICK;
                cnt_nxt  = 1'b0;
                d0_nxt   = 4'd0;
                d1_nxt   = 4'd0;
                d2_nxt   = 3'd0;
                d3_nxt   = 4'd0;
                mode_nxt = ST_EDIT;
              end
            end
          end
        endcase
      end
      default: ;
    endcase
  end

  always_comb begin
    result.minutes_tens   = d0_nxt;
    result.minutes_ones   = d1_nxt;
    result.seconds_tens   = d2_nxt;
    result.seconds_ones   = d3_nxt;
    result.mode           = mode_nxt;
    result.sound_cue      = cue;
    result.digits_changed = (d0_nxt != d0_r) || (d1_nxt != d1_r) ||
                            (d2_nxt != d2_r) || (d3_nxt != d3_r);
    result.alarm_started  = alarm;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= ST_EDIT;
      d0_r   <= 4'd0;
      d1_r   <= 4'd0;
      d2_r   <= 3'd0;
      d3_r   <= 4'd0;
      set_r  <= 13'd0;
      elap_r <= 13'd0;
      sub_r  <= 16'd0;
      cnt_r  <= 1'b0;
    end else if (fire) begin
      mode_r <= mode_nxt;
      d0_r   <= d0_nxt;
      d1_r   <= d1_nxt;
      d2_r   <= d2_nxt;
      d3_r   <= d3_nxt;
      set_r  <= set_nxt;
      elap_r <= elap_nxt;
      sub_r  <= sub_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

endmodule

FILE: design/cdt_checker.sv
// Port-level checks for the countdown timer, bound to the top level.
// Depends on cdt_pkg and countdown_timer_mmss.
module cdt_checker (
  input logic          clk,
  input logic          rst_n,
  input logic          out_valid,
  input logic          out_stall,
  input cdt_pkg::out_t out_data
);

  // Alarm start shows digits 00:00 in sounding mode with no sound cue
  a_alarm_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.alarm_started |->
      out_data.mode == cdt_pkg::MODE_SOUND && out_data.minutes_tens == 4'd0 &&
      out_data.minutes_ones == 4'd0 && out_data.seconds_tens == 3'd0 &&
      out_data.seconds_ones == 4'd0 && out_data.sound_cue == cdt_pkg::CUE_NONE)
    else $error("alarm start without cleared digits in sounding mode");

  // A running timer never shows 00:00
  a_run_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.mode == cdt_pkg::MODE_RUN |->
      out_data.minutes_tens != 4'd0 || out_data.minutes_ones != 4'd0 ||
      out_data.seconds_tens != 3'd0 || out_data.seconds_ones != 4'd0)
    else $error("running mode shows zero time");

  // Tens of seconds stay within 0 to 5
  a_sec_tens: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_data.seconds_tens <= 3'd5)
    else $error("seconds tens digit out of range");

  // A stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled result changed");

endmodule

bind countdown_timer_mmss cdt_checker u_cdt_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);

FILE: verif/countdown_timer_mmss_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for the mm:ss countdown timer (countdown_timer_mmss).
// Depends on cdt_pkg for payload types, button, mode and cue codes and the register map.

// Shadow of the timer: predicts the display after each request and checks results.
class timer_checker;
  logic [15:0]    rate;
  logic [2:0]     run_mode;
  logic [3:0]     digit [4];
  logic [12:0]    set_total;
  logic [12:0]    elapsed;
  logic [15:0]    sub_ticks;
  logic           armed;
  cdt_pkg::out_t  expected_displays[$];
  int             errors;
  int             alarms;

  function new();
    rate      = cdt_pkg::TPS_RESET;
    run_mode  = cdt_pkg::MODE_EDIT;
    clear_digits();
    set_total = '0;
    elapsed   = '0;
    sub_ticks = '0;
    armed     = 1'b0;
    errors    = 0;
    alarms    = 0;
  endfunction

  function void set_rate(logic [15:0] v);
    rate = v;
  endfunction

  function int pending();
    return expected_displays.size();
  endfunction

  function void clear_digits();
    for (int i = 0; i < 4; i++) digit[i] = 4'd0;
  endfunction

  function void show_total(int unsigned total);
    int unsigned m;
    int unsigned s;
    m = total / 60;
    s = total % 60;
    digit[0] = 4'(m / 10);
    digit[1] = 4'(m % 10);
    digit[2] = 4'((s / 10) & 7);
    digit[3] = 4'(s % 10);
  endfunction

  // Step one digit; the tens of seconds wraps at 5, the others at 9.
  function void step_digit(logic [3:0] b);
    int          idx;
    logic        up;
    logic [3:0]  lim;
    case (b)
      cdt_pkg::BTN_MT_UP: begin idx = 0; up = 1'b1; end
      cdt_pkg::BTN_MO_UP: begin idx = 1; up = 1'b1; end
      cdt_pkg::BTN_MT_DN: begin idx = 0; up = 1'b0; end
      cdt_pkg::BTN_MO_DN: begin idx = 1; up = 1'b0; end
      cdt_pkg::BTN_ST_UP: begin idx = 2; up = 1'b1; end
      cdt_pkg::BTN_SO_UP: begin idx = 3; up = 1'b1; end
      cdt_pkg::BTN_ST_DN: begin idx = 2; up = 1'b0; end
      cdt_pkg::BTN_SO_DN: begin idx = 3; up = 1'b0; end
      default: return;
    endcase
    lim = (idx == 2) ? 4'd5 : 4'd9;
    if (up) digit[idx] = (digit[idx] >= lim) ? 4'd0 : digit[idx] + 4'd1;
    else digit[idx] = (digit[idx] == 4'd0 || digit[idx] > lim) ? lim : digit[idx] - 4'd1;
  endfunction

  // Advance the shadow by one accepted request and queue the display it must produce.
  function void take_request(cdt_pkg::in_t r);
    logic [15:0]   prior;
    logic [15:0]   lim;
    logic [1:0]    cue;
    logic          alarm;
    logic          touch;
    int unsigned   total;
    cdt_pkg::out_t e;
    prior = {digit[0], digit[1], digit[2], digit[3]};
    cue   = cdt_pkg::CUE_NONE;
    alarm = 1'b0;
    touch = (r.func == cdt_pkg::FUNC_TOUCH);
    if (r.func == cdt_pkg::FUNC_TICK) begin
      if (run_mode == cdt_pkg::MODE_RUN) begin
        lim = (rate == 16'd0) ? 16'd1 : rate;
        sub_ticks = sub_ticks + 16'd1;
        if (sub_ticks >= lim) begin
          sub_ticks = 16'd0;
          elapsed   = elapsed + 13'd1;
        end
        if (armed) begin
          if (elapsed >= set_total) begin
            armed = 1'b0;
            clear_digits();
            alarm = 1'b1;
            run_mode = cdt_pkg::MODE_SOUND;
          end else begin
            show_total(32'(set_total - elapsed));
          end
        end
      end
    end else if (r.func == cdt_pkg::FUNC_TOUCH || r.func == cdt_pkg::FUNC_REPEAT) begin
      case (run_mode)
        cdt_pkg::MODE_EDIT: begin
          if (touch && r.button == cdt_pkg::BTN_START) begin
            cue = cdt_pkg::CUE_CLICK;
            armed = 1'b1;
            elapsed = '0;
            sub_ticks = '0;
            total = (digit[0] * 10 + digit[1]) * 60 + digit[2] * 10 + digit[3];
            set_total = 13'(total);
            show_total(32'(set_total));
            if (set_total != 13'd0) run_mode = cdt_pkg::MODE_RUN;
          end else if (touch && r.button == cdt_pkg::BTN_STOP) begin
            cue = cdt_pkg::CUE_BEEP;
          end else if (touch && r.button == cdt_pkg::BTN_RESET) begin
            cue = cdt_pkg::CUE_CLICK;
            armed = 1'b0;
            clear_digits();
          end else begin
            step_digit(r.button);
          end
        end
        cdt_pkg::MODE_RUN: begin
          if (touch) begin
            if (r.button == cdt_pkg::BTN_START) begin
              cue = cdt_pkg::CUE_BEEP;
            end else if (r.button == cdt_pkg::BTN_STOP) begin
              cue = cdt_pkg::CUE_CLICK;
              armed = 1'b0;
              run_mode = cdt_pkg::MODE_PAUSE;
            end else if (r.button == cdt_pkg::BTN_RESET) begin
              cue = cdt_pkg::CUE_CLICK;
              armed = 1'b0;
              clear_digits();
              run_mode = cdt_pkg::MODE_EDIT;
            end
          end
        end
        cdt_pkg::MODE_PAUSE: begin
          if (touch) begin
            if (r.button == cdt_pkg::BTN_START) begin
              cue = cdt_pkg::CUE_CLICK;
              armed = 1'b1;
              run_mode = cdt_pkg::MODE_RUN;
            end else if (r.button == cdt_pkg::BTN_STOP) begin
              cue = cdt_pkg::CUE_BEEP;
            end else if (r.button == cdt_pkg::BTN_RESET) begin
              cue = cdt_pkg::CUE_CLICK;
              armed = 1'b0;
              clear_digits();
              run_mode = cdt_pkg::MODE_EDIT;
            end
          end
        end
        cdt_pkg::MODE_SOUND: begin
          if (touch) begin
            if (r.button == cdt_pkg::BTN_START) begin
              cue = cdt_pkg::CUE_BEEP;
            end else if (r.button == cdt_pkg::BTN_STOP) begin
              cue = cdt_pkg::CUE_CLICK;
              run_mode = cdt_pkg::MODE_SILENT;
            end else if (r.button == cdt_pkg::BTN_RESET) begin
              cue = cdt_pkg::CUE_CLICK;
              run_mode = cdt_pkg::MODE_EDIT;
            end
          end
        end
        default: begin
          if (touch) begin
            if (r.button == cdt_pkg::BTN_START) begin
              cue = cdt_pkg::CUE_CLICK;
              run_mode = cdt_pkg::MODE_SOUND;
            end else if (r.button == cdt_pkg::BTN_STOP) begin
              cue = cdt_pkg::CUE_BEEP;
            end else if (r.button == cdt_pkg::BTN_RESET) begin
              cue = cdt_pkg::CUE_CLICK;
              armed = 1'b0;
              clear_digits();
              run_mode = cdt_pkg::MODE_EDIT;
            end
          end
        end
      endcase
    end
    if (alarm) alarms++;
    e.minutes_tens   = digit[0];
    e.minutes_ones   = digit[1];
    e.seconds_tens   = digit[2][2:0];
    e.seconds_ones   = digit[3];
    e.mode           = run_mode;
    e.sound_cue      = cue;
    e.digits_changed = (prior != {digit[0], digit[1], digit[2], digit[3]});
    e.alarm_started  = alarm;
    expected_displays.push_back(e);
  endfunction

  function void compare_field(string field, logic [3:0] want, logic [3:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", field, want, got);
      errors++;
    end
  endfunction

  function void check_display(cdt_pkg::out_t got);
    cdt_pkg::out_t e;
    if (expected_displays.size() == 0) begin
      $error("result arrived with no request outstanding");
      errors++;
      return;
    end
    e = expected_displays.pop_front();
    compare_field("minutes_tens", e.minutes_tens, got.minutes_tens);
    compare_field("minutes_ones", e.minutes_ones, got.minutes_ones);
    compare_field("seconds_tens", 4'(e.seconds_tens), 4'(got.seconds_tens));
    compare_field("seconds_ones", e.seconds_ones, got.seconds_ones);
    compare_field("mode", 4'(e.mode), 4'(got.mode));
    compare_field("sound_cue", 4'(e.sound_cue), 4'(got.sound_cue));
    compare_field("digits_changed", 4'(e.digits_changed), 4'(got.digits_changed));
    compare_field("alarm_started", 4'(e.alarm_started), 4'(got.alarm_started));
  endfunction
endclass

module countdown_timer_mmss_tb;
  // Codes the package leaves unnamed: the spare function and the unused buttons.
  localparam logic [1:0] FUNC_UNDEF    = 2'd3;
  localparam logic [3:0] BTN_SPARE_MIN = 4'd11;
  localparam logic [3:0] BTN_SPARE_MAX = 4'd15;

  localparam int CYCLE_LIMIT  = 500000;
  localparam int PHASE_ITEMS  = 190;
  localparam int LONG_HOLD    = 120;
  localparam int NUM_PHASES   = 6;

  logic                           clk = 1'b0;
  logic                           rst_n;
  logic                           in_valid;
  logic                           in_stall;
  cdt_pkg::in_t                   in_data;
  logic                           out_valid;
  logic                           out_stall;
  cdt_pkg::out_t                  out_data;
  logic                           psel;
  logic                           penable;
  logic                           pwrite;
  logic [cdt_pkg::CFG_ADDR_W-1:0] paddr;
  logic [31:0]                    pwdata;
  logic [31:0]                    prdata;
  logic                           pready;

  timer_checker chk = new();

  int          cycles = 0;
  int          sent = 0;
  int          rates_used = 0;
  logic [15:0] cur_rate;
  bit          sender_idles = 1'b0;
  bit          receiver_idles = 1'b0;
  bit          quiet = 1'b0;
  bit          hold_results_req = 1'b0;

  countdown_timer_mmss dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Watchdog: end the run as a failure once the cycle count reaches CYCLE_LIMIT.
  always @(posedge clk) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  // Sample both channels at the rising edge. A request feeds the shadow first,
  // then any result is checked against the oldest prediction.
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && !in_stall) chk.take_request(in_data);
      if (out_valid && !out_stall) chk.check_display(out_data);
    end
  end

  // Result side: random stall bursts, plus one long hold-off on request so the
  // input register fills and in_stall rises while the sender keeps offering.
  always begin
    @(negedge clk);
    if (hold_results_req) begin
      out_stall <= 1'b1;
      repeat (LONG_HOLD) @(negedge clk);
      hold_results_req = 1'b0;
      out_stall <= 1'b0;
    end else if (receiver_idles && !quiet && $urandom_range(0, 5) == 0) begin
      out_stall <= 1'b1;
      repeat ($urandom_range(1, 10)) @(negedge clk);
      out_stall <= 1'b0;
    end
  end

  // Drop valid and idle the sender for a time set by n.
  task automatic pause_sender(input int n);
    @(negedge clk);
    in_valid <= 1'b0;
    repeat (n - 1) @(negedge clk);
  endtask

  // Offer one request and hold it until taken. Valid stays high afterward so
  // back-to-back requests need no extra edge.
  task automatic send_request(input logic [1:0] f, input logic [3:0] b);
    cdt_pkg::in_t r;
    if (sender_idles && !quiet && $urandom_range(0, 7) == 0)
      pause_sender($urandom_range(1, 10));
    r.func   = f;
    r.button = b;
    @(negedge clk);
    in_valid <= 1'b1;
    in_data  <= r;
    do @(posedge clk); while (in_stall);
    sent++;
  endtask

  task automatic send_noise();
    send_request(2'($urandom_range(0, 3)), 4'($urandom_range(0, 15)));
  endtask

  // Stop offering and wait until every predicted result has come back.
  task automatic drain_results();
    @(negedge clk);
    in_valid <= 1'b0;
    while (chk.pending() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  // APB write of ticks_per_second: setup cycle, then access cycle.
  task automatic write_rate(input logic [15:0] v);
    @(negedge clk);
    psel    <= 1'b1;
    pwrite  <= 1'b1;
    penable <= 1'b0;
    paddr   <= {cdt_pkg::REG_TPS, 2'b00};
    pwdata  <= {16'd0, v};
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    chk.set_rate(v);
    cur_rate = v;
    rates_used++;
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // One well-formed session: clear, set a time, start, tick toward expiry
  // with the odd pause or stray request, then poke at the alarm.
  task automatic run_countdown();
    int          presses;
    int          pick;
    int          n;
    int          want;
    int          eff;
    logic [3:0]  b;
    logic [1:0]  f;
    send_request(cdt_pkg::FUNC_TOUCH, cdt_pkg::BTN_RESET);
    presses = $urandom_range(1, 4);
    repeat (presses) begin
      pick = $urandom_range(0, 99);
      if (pick < 60) b = cdt_pkg::BTN_SO_UP;
      else if (pick < 70) b = cdt_pkg::BTN_ST_UP;
      else if (pick < 75) b = cdt_pkg::BTN_SO_DN;
      else if (pick < 80) b = cdt_pkg::BTN_ST_DN;
      else if (pick < 85) b = cdt_pkg::BTN_MO_UP;
      else if (pick < 90) b = cdt_pkg::BTN_MO_DN;
      else if (pick < 95) b = cdt_pkg::BTN_MT_UP;
      else b = cdt_pkg::BTN_MT_DN;
      send_request($urandom_range(0, 1) ? cdt_pkg::FUNC_TOUCH : cdt_pkg::FUNC_REPEAT, b);
    end
    send_request(cdt_pkg::FUNC_TOUCH, cdt_pkg::BTN_START);
    eff  = (cur_rate == 16'd0) ? 1 : cur_rate;
    n    = 0;
    want = 400;
    while (n < want) begin
      pick = $urandom_range(0, 99);
      if (pick < 4) begin
        // pause, let ticks fall on the paused timer, resume
        send_request(cdt_pkg::FUNC_TOUCH, cdt_pkg::BTN_STOP);
        repeat ($urandom_range(0, 3))
          send_request(cdt_pkg::FUNC_TICK, 4'($urandom_range(0, 15)));
        send_request(cdt_pkg::FUNC_TOUCH, cdt_pkg::BTN_START);
      end else if (pick < 6) begin
        send_noise();
      end else begin
        send_request(cdt_pkg::FUNC_TICK, 4'($urandom_range(0, 15)));
      end
      n++;
      // The start is in the shadow by now; size the run from its set time.
      if (n == 1) begin
        want = chk.set_total * eff + 3;
        if (want > 300) want = $urandom_range(10, 60);
      end
      if (n >= 2 && (chk.run_mode == cdt_pkg::MODE_SOUND ||
                     chk.run_mode == cdt_pkg::MODE_SILENT ||
                     chk.run_mode == cdt_pkg::MODE_EDIT))
        break;
    end
    repeat ($urandom_range(0, 3)) begin
      pick = $urandom_range(0, 4);
      case (pick)
        0: begin f = cdt_pkg::FUNC_TOUCH;  b = cdt_pkg::BTN_STOP;  end
        1: begin f = cdt_pkg::FUNC_TOUCH;  b = cdt_pkg::BTN_START; end
        2: begin f = cdt_pkg::FUNC_REPEAT; b = cdt_pkg::BTN_STOP;  end
        3: begin f = cdt_pkg::FUNC_TICK;   b = cdt_pkg::BTN_START; end
        default: begin f = cdt_pkg::FUNC_TOUCH; b = cdt_pkg::BTN_RESET; end
      endcase
      send_request(f, b);
    end
  endtask

  task automatic random_phase(input int items);
    int first;
    first = sent;
    while (sent - first < items) begin
      if ($urandom_range(0, 4) == 0) repeat ($urandom_range(1, 5)) send_noise();
      else run_countdown();
    end
  endtask

  logic [15:0] phase_rates [NUM_PHASES];

  initial begin
    // Hold every input at a known value from time zero.
    rst_n     = 1'b0;
    in_valid  = 1'b0;
    in_data   = '0;
    out_stall = 1'b0;
    psel      = 1'b0;
    penable   = 1'b0;
    pwrite    = 1'b0;
    paddr     = '0;
    pwdata    = '0;
    cur_rate  = cdt_pkg::TPS_RESET;
    phase_rates = '{16'd2, 16'd0, 16'hFFFF, 16'd3, 16'd60, 16'd1};

    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed part at one tick per second so expiry comes fast.
    write_rate(16'd1);
    send_request(cdt_pkg::FUNC_TICK, cdt_pkg::BTN_START);    // tick in edit is ignored
    send_request(cdt_pkg::FUNC_TOUCH, cdt_pkg::BTN_START);   // start at 00:00: click, stays in edit
    send_request(cdt_pkg::FUNC_TOUCH, cdt_pkg::BTN_RESET);   // drop the armed flag again
    send_request(FUNC_UNDEF, BTN_SPARE_MAX);                 // spare function does nothing
    send_request(cdt_pkg::FUNC_TOUCH, BTN_SPARE_MIN);        // unused button, no cue
    send_request(cdt_pkg::FUNC_TOUCH, cdt_pkg::BTN_STOP);    // stop in edit beeps
    // wrap each digit both ways
    send_request(cdt_pkg::FUNC_TOUCH, cdt_pkg::BTN_MT_DN);
    send_request(cdt_pkg::FUNC_REPEAT, cdt_pkg::BTN_MT_UP);
    send_request(cdt_pkg::FUNC_TOUCH, cdt_pkg::BTN_MO_DN);
    send_request(cdt_pkg::FUNC_TOUCH, cdt_pkg::BTN_MO_UP);
    send_request(cdt_pkg::FUNC_REPEAT, cdt_pkg::BTN_ST_DN);
    send_request(cdt_pkg::FUNC_TOUCH, cdt_pkg::BTN_ST_UP);
    send_request(cdt_pkg::FUNC_REPEAT, cdt_pkg::BTN_SO_DN);
    send_request(cdt_pkg::FUNC_REPEAT, cdt_pkg::BTN_SO_UP);
    send_request(cdt_pkg::FUNC_REPEAT, cdt_pkg::BTN_SO_UP);
    send_request(cdt_pkg::FUNC_REPEAT, cdt_pkg::BTN_SO_UP);  // set 00:02
    send_request(cdt_pkg::FUNC_REPEAT, cdt_pkg::BTN_START);  // repeated start does nothing
    send_request(cdt_pkg::FUNC_TOUCH, cdt_pkg::BTN_START);   // run
    send_request(cdt_pkg::FUNC_TOUCH, cdt_pkg::BTN_START);   // start while running beeps
    send_request(cdt_pkg::FUNC_REPEAT, cdt_pkg::BTN_STOP);   // repeats ignored outside edit
    send_request(cdt_pkg::FUNC_TICK, cdt_pkg::BTN_START);    // 00:01
    send_request(cdt_pkg::FUNC_TOUCH, cdt_pkg::BTN_STOP);    // pause
    send_request(cdt_pkg::FUNC_TICK, cdt_pkg::BTN_START);    // tick while paused is ignored
    send_request(cdt_pkg::FUNC_TOUCH, cdt_pkg::BTN_START);   // resume
    send_request(cdt_pkg::FUNC_TICK, cdt_pkg::BTN_START);    // expiry, alarm
    send_request(cdt_pkg::FUNC_TOUCH, cdt_pkg::BTN_STOP);    // silence
    send_request(cdt_pkg::FUNC_TOUCH, cdt_pkg::BTN_START);   // sound again
    send_request(cdt_pkg::FUNC_TOUCH, cdt_pkg::BTN_RESET);   // back to edit from sounding

    // Random phases, one tick rate each, rewritten only with nothing in flight.
    for (int p = 0; p < NUM_PHASES; p++) begin
      drain_results();
      write_rate(phase_rates[p]);
      if (p == NUM_PHASES - 1) begin
        quiet = 1'b1;  // last phase runs at full rate on both sides
      end else begin
        sender_idles   = (p % 2 == 0) || ($urandom_range(0, 1) == 1);
        receiver_idles = (p % 2 == 0) || ($urandom_range(0, 1) == 1);
      end
      if (p == 1) hold_results_req = 1'b1;
      random_phase(PHASE_ITEMS);
    end

    // Let the pipeline empty, then idle to catch anything stray.
    drain_results();
    repeat (5) @(posedge clk);

    $display("Sent %0d requests across %0d tick-rate settings (0, 1 and 65535 included).",
             sent, rates_used);
    $display("Countdowns expired: %0d; check failures: %0d.", chk.alarms, chk.errors);
    if (chk.errors == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end
endmodule
